// ===== rtl/wsp_pkg.sv =====
// Shared constants, types and helpers of the world-to-screen projection block.
`default_nettype none
package wsp_pkg;

  // Coefficient and datapath widths
  localparam int COEF_BITS   = 16;
  localparam int IN_W        = 32;
  localparam int ROW_W       = 64;
  localparam int DIM_W       = 14;
  localparam int PIX_W       = 32;
  localparam int FRAC_BITS   = COEF_BITS - 4;
  localparam int ACC_SHIFT   = 16 + FRAC_BITS;
  localparam int PROD_W      = COEF_BITS + IN_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int NUM_W       = ACC_W + 1;
  localparam int D_W         = ACC_W - 1;
  localparam int MAG_W       = NUM_W;
  localparam int LO_W        = (MAG_W + 1) / 2;
  localparam int HI_W        = MAG_W - LO_W;
  localparam int SCALE_SH    = 7;
  localparam int N_W         = MAG_W + DIM_W + SCALE_SH;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [DIM_W-1:0] VP_W_RESET = DIM_W'(1920);
  localparam logic [DIM_W-1:0] VP_H_RESET = DIM_W'(1080);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X  = 3'd0,
    REG_ROW_Y  = 3'd1,
    REG_ROW_W  = 3'd2,
    REG_VP_W   = 3'd3,
    REG_VP_H   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_x;
    logic [ROW_W-1:0] row_y;
    logic [ROW_W-1:0] row_w;
    logic [DIM_W-1:0] vp_w;
    logic [DIM_W-1:0] vp_h;
  } wsp_cfg_t;

  // Word passed from the front to the back
  typedef struct packed {
    logic                    vis;
    logic signed [NUM_W-1:0] num_x;
    logic signed [NUM_W-1:0] num_y;
    logic [D_W-1:0]          w;
  } queue_word_t;

  // Low COEF_BITS of a 16-bit slot, two's complement
  function automatic logic signed [COEF_BITS-1:0] coef_of(input logic [ROW_W-1:0] row,
                                                          input logic [1:0] slot);
    coef_of = row[{slot, 4'b0000} +: COEF_BITS];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/wsp_if.sv =====
// Channel interfaces: input points, screen results and register writes.
`default_nettype none
interface wsp_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [wsp_pkg::IN_W-1:0] world_x;
  logic signed [wsp_pkg::IN_W-1:0] world_y;
  logic signed [wsp_pkg::IN_W-1:0] world_z;
  modport source (output valid, world_x, world_y, world_z, input ready);
  modport sink (input valid, world_x, world_y, world_z, output ready);
endinterface

interface wsp_out_if;
  logic                             valid;
  logic                             ready;
  logic                             visible;
  logic signed [wsp_pkg::PIX_W-1:0] pixel_x;
  logic signed [wsp_pkg::PIX_W-1:0] pixel_y;
  modport source (output valid, visible, pixel_x, pixel_y, input ready);
  modport sink (input valid, visible, pixel_x, pixel_y, output ready);
endinterface

interface wsp_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [wsp_pkg::CFG_IDX_W-1:0]        index;
  logic [wsp_pkg::ROW_W-1:0]            data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/wsp_front.sv =====
// Front pipeline: linear forms, visibility test and numerators.
`default_nettype none
module wsp_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire wsp_pkg::wsp_cfg_t               cfg,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [wsp_pkg::IN_W-1:0] world_x,
  input  wire logic signed [wsp_pkg::IN_W-1:0] world_y,
  input  wire logic signed [wsp_pkg::IN_W-1:0] world_z,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output wsp_pkg::queue_word_t                 q_word
);
  import wsp_pkg::*;

  localparam logic signed [ACC_W+3:0] W_MIN10 = (ACC_W+4)'(1) <<< ACC_SHIFT;

  logic                     en;
  logic                     va, vb, vc, vd;
  logic signed [IN_W-1:0]   pa [3];
  logic signed [PROD_W-1:0] prod [3][3];
  logic signed [COEF_BITS-1:0] off_b [3];
  logic signed [ACC_W-1:0]  acc [3];
  logic signed [ACC_W+3:0]  w10;
  queue_word_t              word_d;
  logic [ROW_W-1:0]         rows [3];

  assign rows[0] = cfg.row_x;
  assign rows[1] = cfg.row_y;
  assign rows[2] = cfg.row_w;

  // Advance unless the last stage is stuck on a full queue
  assign en       = !vd || !q_full;
  assign in_ready = en;
  assign q_push   = vd && !q_full;
  assign q_word   = word_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
  end

  // Stage A: capture the point
  always_ff @(posedge clk) begin
    if (en) begin
      pa[0] <= world_x;
      pa[1] <= world_y;
      pa[2] <= world_z;
    end
  end

  // Stage B: nine coefficient products, plus the offset coefficients
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= PROD_W'(coef_of(rows[r], 2'(c))) * PROD_W'(pa[c]);
        end
        off_b[r] <= coef_of(rows[r], 2'd3);
      end
    end
  end

  // Stage C: sum each row
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        acc[r] <= ACC_W'(prod[r][0]) + ACC_W'(prod[r][1]) + ACC_W'(prod[r][2])
                + {{(ACC_W-COEF_BITS-16){off_b[r][COEF_BITS-1]}}, off_b[r], 16'h0000};
      end
    end
  end

  // Stage D: test w against 0.1 and form the numerators
  assign w10 = ((ACC_W+4)'(acc[2]) <<< 3) + ((ACC_W+4)'(acc[2]) <<< 1);

  always_ff @(posedge clk) begin
    if (en) begin
      word_d.vis   <= !acc[2][ACC_W-1] && (w10 >= W_MIN10);
      word_d.num_x <= NUM_W'(acc[0]) + NUM_W'(acc[2]);
      word_d.num_y <= NUM_W'(acc[2]) - NUM_W'(acc[1]);
      word_d.w     <= acc[2][D_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wsp_queue.sv =====
// Short queue between the front and back pipelines.
`default_nettype none
module wsp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire wsp_pkg::queue_word_t push_word,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      head_valid,
  output wsp_pkg::queue_word_t      head_word
);
  import wsp_pkg::*;

  queue_word_t       mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_word  = mem[rptr];

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_word;
    end
  end

  // Move pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("queue written while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== rtl/wsp_back.sv =====
// Back pipeline: viewport scaling, 32-stage divide, rounding and saturation.
`default_nettype none
module wsp_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire wsp_pkg::wsp_cfg_t    cfg,
  input  wire logic                 q_valid,
  input  wire wsp_pkg::queue_word_t q_word,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      visible,
  output logic signed [wsp_pkg::PIX_W-1:0] pixel_x,
  output logic signed [wsp_pkg::PIX_W-1:0] pixel_y
);
  import wsp_pkg::*;

  localparam int QB    = 32;
  localparam int HN_W  = N_W - QB;
  localparam int CMP_W = (HN_W > D_W) ? HN_W : D_W;

  typedef struct packed {
    logic           ovf;
    logic [D_W-1:0] rem;
    logic [QB-1:0]  low;
    logic [QB-1:0]  quo;
  } div_t;

  typedef struct packed {
    logic           vis;
    logic           neg_x;
    logic           neg_y;
    logic [D_W-1:0] d;
  } side_t;

  logic adv;
  logic vm, vn;
  logic vdiv [QB+1];

  // Multiply stage
  side_t                   side_m, side_n;
  logic [LO_W+DIM_W-1:0]   plo_x, plo_y;
  logic [HI_W+DIM_W-1:0]   phi_x, phi_y;
  logic [MAG_W-1:0]        mag_x, mag_y;
  // Product stage
  logic [N_W-1:0]          n_x, n_y;
  // Divide stages
  div_t                    dx [QB+1];
  div_t                    dy [QB+1];
  side_t                   sd [QB+1];

  function automatic div_t div_step(input div_t s, input logic [D_W-1:0] d);
    logic [D_W:0] rs;
    logic         ge;
    div_t         o;
    rs    = {s.rem, s.low[QB-1]};
    ge    = (rs >= {1'b0, d});
    o.ovf = s.ovf;
    o.rem = ge ? D_W'(rs - {1'b0, d}) : rs[D_W-1:0];
    o.low = {s.low[QB-2:0], 1'b0};
    o.quo = {s.quo[QB-2:0], ge};
    return o;
  endfunction

  function automatic div_t div_start(input logic [N_W-1:0] n, input logic [D_W-1:0] d);
    div_t o;
    o.ovf = CMP_W'(n[N_W-1:QB]) >= CMP_W'(d);
    o.rem = D_W'(n[N_W-1:QB]);
    o.low = n[QB-1:0];
    o.quo = '0;
    return o;
  endfunction

  // Round half up on the remainder, then saturate and apply sign
  function automatic logic [PIX_W-1:0] finish(input div_t s, input logic [D_W-1:0] d,
                                              input logic neg);
    logic          rnd;
    logic [QB:0]   q;
    logic          big;
    rnd = ({s.rem, 1'b0} >= {1'b0, d});
    q   = {1'b0, s.quo} + (QB+1)'(rnd);
    big = s.ovf || q[QB];
    if (neg) begin
      if (big || q[QB-1]) finish = {1'b1, {(PIX_W-1){1'b0}}};
      else                finish = PIX_W'(-q[QB-1:0]);
    end else begin
      if (big || q[QB-1]) finish = {1'b0, {(PIX_W-1){1'b1}}};
      else                finish = q[QB-1:0];
    end
  endfunction

  // Whole pipeline moves while the output slot is free or being taken
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && q_valid;

  assign mag_x = q_word.num_x[NUM_W-1] ? MAG_W'(-q_word.num_x) : MAG_W'(q_word.num_x);
  assign mag_y = q_word.num_y[NUM_W-1] ? MAG_W'(-q_word.num_y) : MAG_W'(q_word.num_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      vm        <= 1'b0;
      vn        <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i <= QB; i++) vdiv[i] <= 1'b0;
    end else if (adv) begin
      vm      <= q_valid;
      vn      <= vm;
      vdiv[0] <= vn;
      for (int i = 1; i <= QB; i++) vdiv[i] <= vdiv[i-1];
      out_valid <= vdiv[QB];
    end
  end

  // Split multiplies by the viewport size
  always_ff @(posedge clk) begin
    if (adv) begin
      plo_x        <= (LO_W+DIM_W)'(mag_x[LO_W-1:0]) * (LO_W+DIM_W)'(cfg.vp_w);
      phi_x        <= (HI_W+DIM_W)'(mag_x[MAG_W-1:LO_W]) * (HI_W+DIM_W)'(cfg.vp_w);
      plo_y        <= (LO_W+DIM_W)'(mag_y[LO_W-1:0]) * (LO_W+DIM_W)'(cfg.vp_h);
      phi_y        <= (HI_W+DIM_W)'(mag_y[MAG_W-1:LO_W]) * (HI_W+DIM_W)'(cfg.vp_h);
      side_m.vis   <= q_word.vis;
      side_m.neg_x <= q_word.num_x[NUM_W-1];
      side_m.neg_y <= q_word.num_y[NUM_W-1];
      side_m.d     <= q_word.w;
    end
  end

  // Combine partial products and scale by 128
  always_ff @(posedge clk) begin
    if (adv) begin
      n_x    <= ((N_W'(phi_x) << LO_W) + N_W'(plo_x)) << SCALE_SH;
      n_y    <= ((N_W'(phi_y) << LO_W) + N_W'(plo_y)) << SCALE_SH;
      side_n <= side_m;
    end
  end

  // Divide: overflow check and one quotient bit per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      dx[0] <= div_start(n_x, side_n.d);
      dy[0] <= div_start(n_y, side_n.d);
      sd[0] <= side_n;
      for (int i = 1; i <= QB; i++) begin
        dx[i] <= div_step(dx[i-1], sd[i-1].d);
        dy[i] <= div_step(dy[i-1], sd[i-1].d);
        sd[i] <= sd[i-1];
      end
    end
  end

  // Output register; invisible points give zero
  always_ff @(posedge clk) begin
    if (adv) begin
      visible <= sd[QB].vis;
      pixel_x <= sd[QB].vis ? finish(dx[QB], sd[QB].d, sd[QB].neg_x) : '0;
      pixel_y <= sd[QB].vis ? finish(dy[QB], sd[QB].d, sd[QB].neg_y) : '0;
    end
  end

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |-> pixel_x == '0 && pixel_y == '0)
    else $error("hidden point with nonzero pixels");
  a_pop_flows: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> vm)
    else $error("popped word lost before multiply stage");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vdiv[QB]) && $stable(vn))
    else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

// ===== rtl/world_to_screen_projection_top.sv =====
// Top level: register file and front, queue and back of the projection block.
//
//  channel  | dir | word
//  ---------+-----+---------------------------------------------
//  in_ch    | in  | world_x, world_y, world_z (signed Q16.16)
//  out_ch   | out | visible, pixel_x, pixel_y (signed Q24.8)
//  cfg_ch   | in  | index (3 bits), data (64 bits), always ready
//
// One point enters per cycle and one result leaves per cycle when unstalled.
// Stages: four front stages, the queue, two multiply stages, the 33-stage divide
// pipeline (overflow check, then a quotient bit per stage) and the output register.
// Reset clears all valid state and loads default registers; no clearing pass.
// Output stall freezes the back; the four-word queue absorbs the front until full.
`default_nettype none
module world_to_screen_projection_top (
  input wire logic clk,
  input wire logic rst,
  wsp_in_if.sink   in_ch,
  wsp_out_if.source out_ch,
  wsp_cfg_if.sink  cfg_ch
);
  import wsp_pkg::*;

  wsp_cfg_t    cfg;
  logic        q_full, q_push, q_pop, q_valid;
  queue_word_t q_in, q_head;

  assign cfg_ch.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_x <= '0;
      cfg.row_y <= '0;
      cfg.row_w <= '0;
      cfg.vp_w  <= VP_W_RESET;
      cfg.vp_h  <= VP_H_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_ROW_X: cfg.row_x <= cfg_ch.data;
        REG_ROW_Y: cfg.row_y <= cfg_ch.data;
        REG_ROW_W: cfg.row_w <= cfg_ch.data;
        REG_VP_W:  cfg.vp_w  <= cfg_ch.data[DIM_W-1:0];
        REG_VP_H:  cfg.vp_h  <= cfg_ch.data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  wsp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .world_x  (in_ch.world_x),
    .world_y  (in_ch.world_y),
    .world_z  (in_ch.world_z),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_word   (q_in)
  );

  wsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_word  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_word  (q_head)
  );

  wsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_word    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .visible   (out_ch.visible),
    .pixel_x   (out_ch.pixel_x),
    .pixel_y   (out_ch.pixel_y)
  );

endmodule
`default_nettype wire

// ===== test/wsp_projection_checker.sv =====
// Watches the projection channels, predicts each screen result and compares it.
`default_nettype none
module wsp_projection_checker
  import wsp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  wsp_in_if.sink    in_mon,
  wsp_out_if.sink   out_mon,
  wsp_cfg_if.sink   cfg_mon,
  output int        fail_count,
  output int        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                    visible;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
  } screen_word_t;

  logic [ROW_W-1:0] row_x, row_y, row_w;
  logic [DIM_W-1:0] vp_w, vp_h;
  screen_word_t     screen_q[$];

  assign pending_count = screen_q.size();

  function automatic longint coef_val(input logic [ROW_W-1:0] row, input int slot);
    logic signed [COEF_BITS-1:0] c;
    c = row[16*slot +: COEF_BITS];
    return longint'(c);
  endfunction

  function automatic longint row_dot(input logic [ROW_W-1:0] row,
                                     input longint x, input longint y, input longint z);
    return coef_val(row, 0) * x + coef_val(row, 1) * y + coef_val(row, 2) * z
         + coef_val(row, 3) * 65536;
  endfunction

  // round(num * dim * 128 / w), ties away from zero, saturate to 32 bits
  function automatic logic signed [PIX_W-1:0] pixel_scale(input longint num,
                                                          input logic [DIM_W-1:0] dim,
                                                          input longint w);
    logic [127:0] prod, q, r;
    logic [63:0]  mag;
    mag  = (num < 0) ? 64'(-num) : 64'(num);
    prod = 128'(mag) * 128'(dim) * 128'd128;
    q = prod / 128'(w);
    r = prod % 128'(w);
    if (r >= 128'(w) - r) q = q + 1;
    if (num < 0) begin
      if (q >= 128'h8000_0000) return 32'sh8000_0000;
      return -$signed(32'(q));
    end
    if (q > 128'h7FFF_FFFF) return 32'sh7FFF_FFFF;
    return 32'(q);
  endfunction

  function automatic screen_word_t project_point(input logic [IN_W-1:0] wx,
                                                 input logic [IN_W-1:0] wy,
                                                 input logic [IN_W-1:0] wz);
    screen_word_t s;
    longint x, y, z, w, nx, ny;
    x = longint'($signed(wx));
    y = longint'($signed(wy));
    z = longint'($signed(wz));
    w = row_dot(row_w, x, y, z);
    s = '0;
    if (w < 0 || w * 10 < (longint'(1) <<< ACC_SHIFT)) return s;
    nx = row_dot(row_x, x, y, z);
    ny = row_dot(row_y, x, y, z);
    s.visible = 1'b1;
    s.pixel_x = pixel_scale(nx + w, vp_w, w);
    s.pixel_y = pixel_scale(w - ny, vp_h, w);
    return s;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    screen_word_t want, got;
    if (rst) begin
      row_x <= '0;
      row_y <= '0;
      row_w <= '0;
      vp_w  <= VP_W_RESET;
      vp_h  <= VP_H_RESET;
      screen_q.delete();
      fail_count = 0;
    end else begin
      // track register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (reg_idx_t'(cfg_mon.index))
          REG_ROW_X: row_x <= cfg_mon.data;
          REG_ROW_Y: row_y <= cfg_mon.data;
          REG_ROW_W: row_w <= cfg_mon.data;
          REG_VP_W:  vp_w  <= cfg_mon.data[DIM_W-1:0];
          REG_VP_H:  vp_h  <= cfg_mon.data[DIM_W-1:0];
          default: ;
        endcase
      end
      // predict each accepted point
      if (in_mon.valid && in_mon.ready)
        screen_q.push_back(project_point(in_mon.world_x, in_mon.world_y, in_mon.world_z));
      // compare each accepted result with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.visible, out_mon.pixel_x, out_mon.pixel_y};
        if (screen_q.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = screen_q.pop_front();
          if (got.visible !== want.visible)
            report_mismatch($sformatf("visible %b want %b", got.visible, want.visible));
          if (got.pixel_x !== want.pixel_x)
            report_mismatch($sformatf("pixel_x %h want %h", got.pixel_x, want.pixel_x));
          if (got.pixel_y !== want.pixel_y)
            report_mismatch($sformatf("pixel_y %h want %h", got.pixel_y, want.pixel_y));
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== test/world_to_screen_projection_top_test.sv =====
// Stimulus and verdict for the world-to-screen projection block.
`default_nettype none
module world_to_screen_projection_top_test;
  import wsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 60;
  localparam int CYCLE_LIMIT = 400000;

  logic clk, rst;
  int   fail_count, pending_count;
  int   cycle_count = 0;
  bit   calm;

  wsp_in_if  in_ch();
  wsp_out_if out_ch();
  wsp_cfg_if cfg_ch();

  world_to_screen_projection_top u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  wsp_projection_checker u_checker (
    .clk(clk), .rst(rst), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .cfg_mon(cfg_ch.sink), .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stall the result side in random bursts
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 9);
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // drive one register word; back to back writes reassign valid in the same step
  task automatic write_reg(input reg_idx_t idx, input logic [ROW_W-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // send one point, with an idle burst first now and then
  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.world_x <= x;
    in_ch.world_y <= y;
    in_ch.world_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 8192)) - 16'd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endcase
  endfunction

  initial begin
    logic [63:0] dir_rows[3];
    int phase;
    rst = 1'b1;
    calm = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.world_x = '0;
    in_ch.world_y = '0;
    in_ch.world_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // reset setting: w is zero, nothing visible
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    drain();

    // identity-like view, w = z; probe threshold, extremes and saturation
    write_reg(REG_ROW_X, {16'h0000, 16'h0000, 16'h0000, 16'h1000});
    write_reg(REG_ROW_Y, {16'h0000, 16'h0000, 16'h1000, 16'h0000});
    write_reg(REG_ROW_W, {16'h0000, 16'h1000, 16'h0000, 16'h0000});
    write_reg(REG_VP_W, 64'd8192);
    write_reg(REG_VP_H, 64'd1);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_1999);  // just below 0.1
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_199A);  // just at or above 0.1
    send_point(32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000);  // behind the eye
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_199A);  // saturates both ways
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_199A);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h0000_4000, 32'h0000_C000, 32'h0002_0000);  // fractional inputs that divide exactly
    drain();
    write_reg(REG_VP_W, 64'd0);
    write_reg(REG_VP_H, 64'hFFFF_FFFF_FFFF_3FFF);
    send_point(32'h0000_3000, 32'hFFFF_5000, 32'h0001_0000);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    drain();
    // extreme coefficients and ignored index
    write_reg(REG_ROW_X, 64'h8000_7FFF_8000_7FFF);
    write_reg(REG_ROW_Y, 64'h7FFF_8000_7FFF_8000);
    write_reg(REG_ROW_W, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(reg_idx_t'(3'd7), 64'hDEAD_BEEF_0000_0001);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    drain();

    // random phases: new matrix and viewport, then a batch of points
    for (phase = 0; phase < 16; phase++) begin
      if (phase == 13) calm = 1'b1;
      dir_rows[0] = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
      dir_rows[1] = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
      // mostly a forward-facing w so most points are visible
      if ($urandom_range(0, 3) != 0)
        dir_rows[2] = {16'($urandom_range(0, 16'h3000)), 16'($urandom_range(16'h0800, 16'h1800)),
                       16'($urandom_range(0, 16'h0200)), 16'($urandom_range(0, 16'h0200))};
      else
        dir_rows[2] = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
      write_reg(REG_ROW_X, dir_rows[0]);
      write_reg(REG_ROW_Y, dir_rows[1]);
      write_reg(REG_ROW_W, dir_rows[2]);
      write_reg(REG_VP_W, 64'($urandom_range(0, 16383)));
      write_reg(REG_VP_H, 64'($urandom_range(1, 8192)));
      repeat (50) begin
        if ($urandom_range(0, 3) == 0)
          send_point($urandom, $urandom, $urandom);
        else
          send_point(rand_coord(), rand_coord(), 32'($urandom_range(0, 32'h0100_0000)));
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
